[hdl/wsd_pkg.sv]
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared codes, widths and the result struct of the frame deframer.
// ----------------------------------------------------------------------------
package wsd_pkg;

   localparam int PHASE_W = 3;

   localparam logic [PHASE_W-1:0] PH_HDR0    = 3'd0;
   localparam logic [PHASE_W-1:0] PH_HDR1    = 3'd1;
   localparam logic [PHASE_W-1:0] PH_EXTLEN  = 3'd2;
   localparam logic [PHASE_W-1:0] PH_KEY     = 3'd3;
   localparam logic [PHASE_W-1:0] PH_PAYLOAD = 3'd4;
   localparam logic [PHASE_W-1:0] PH_CLOSED  = 3'd5;

   localparam logic [3:0] OP_TEXT  = 4'h1;
   localparam logic [3:0] OP_CLOSE = 4'h8;

   localparam logic [6:0] LEN_EXT16 = 7'd126;
   localparam logic [6:0] LEN_EXT64 = 7'd127;

   localparam logic [2:0] EXT16_LEFT = 3'd1;
   localparam logic [2:0] EXT64_LEFT = 3'd7;
   localparam logic [2:0] KEY_LEFT   = 3'd3;

   typedef struct packed {
      logic       emit;
      logic [7:0] payload_byte;
      logic       last_in_frame;
      logic       empty_frame;
      logic       close_seen;
   } res_type;

endpackage

[hdl/wsd_parser.sv]
// ----------------------------------------------------------------------------
// wsd_parser
// Frame header and payload parser: one byte per step, state held here,
// result of the step produced combinationally.
// ----------------------------------------------------------------------------
module wsd_parser (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  logic [7:0]       data_byte,
   output wsd_pkg::res_type res
);
   import wsd_pkg::*;

   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [3:0]         kind_ff, kind_in;
   logic               mask_ff, mask_in;
   logic [2:0]         left_ff, left_in;
   logic [63:0]        rem_ff, rem_in;
   logic [31:0]        key_ff, key_in;
   logic [1:0]         pos_ff, pos_in;

   logic        len_done;
   logic [63:0] len_value;
   logic        len_mask;
   logic        hdr_done;
   logic [63:0] hdr_rem;
   logic [63:0] rem_shift;
   logic [7:0]  key_byte;
   logic [6:0]  len7;

   always_comb begin
      phase_in  = phase_ff;
      kind_in   = kind_ff;
      mask_in   = mask_ff;
      left_in   = left_ff;
      rem_in    = rem_ff;
      key_in    = key_ff;
      pos_in    = pos_ff;
      res       = '0;
      len_done  = 1'b0;
      len_value = rem_ff;
      len_mask  = mask_ff;
      hdr_done  = 1'b0;
      hdr_rem   = rem_ff;
      len7      = data_byte[6:0];
      rem_shift = {rem_ff[55:0], data_byte};
      case (pos_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase

      case (phase_ff)
         PH_HDR0: begin
            kind_in  = data_byte[3:0];
            phase_in = PH_HDR1;
         end
         PH_HDR1: begin
            mask_in = data_byte[7];
            key_in  = '0;
            rem_in  = '0;
            if (len7 == LEN_EXT16) begin
               left_in  = EXT16_LEFT;
               phase_in = PH_EXTLEN;
            end else if (len7 == LEN_EXT64) begin
               left_in  = EXT64_LEFT;
               phase_in = PH_EXTLEN;
            end else begin
               rem_in    = {57'd0, len7};
               len_done  = 1'b1;
               len_value = {57'd0, len7};
               len_mask  = data_byte[7];
            end
         end
         PH_EXTLEN: begin
            rem_in = rem_shift;
            if (left_ff == 3'd0) begin
               len_done  = 1'b1;
               len_value = rem_shift;
            end else begin
               left_in = left_ff - 3'd1;
            end
         end
         PH_KEY: begin
            key_in = {key_ff[23:0], data_byte};
            if (left_ff == 3'd0) begin
               hdr_done = 1'b1;
            end else begin
               left_in = left_ff - 3'd1;
            end
         end
         PH_PAYLOAD: begin
            rem_in = rem_ff - 64'd1;
            pos_in = pos_ff + 2'd1;
            if (rem_ff == 64'd1) begin
               phase_in = PH_HDR0;
            end
            if (kind_ff == OP_TEXT) begin
               res.emit          = 1'b1;
               res.payload_byte  = data_byte ^ key_byte;
               res.last_in_frame = (rem_ff == 64'd1);
            end
         end
         default: begin
         end
      endcase

      if (len_done) begin
         if (len_mask) begin
            phase_in = PH_KEY;
            left_in  = KEY_LEFT;
         end else begin
            hdr_done = 1'b1;
            hdr_rem  = len_value;
         end
      end

      if (hdr_done) begin
         pos_in = 2'd0;
         if (kind_ff == OP_CLOSE) begin
            phase_in          = PH_CLOSED;
            res.emit          = 1'b1;
            res.last_in_frame = 1'b1;
            res.close_seen    = 1'b1;
         end else if (hdr_rem == 64'd0) begin
            phase_in = PH_HDR0;
            if (kind_ff == OP_TEXT) begin
               res.emit          = 1'b1;
               res.last_in_frame = 1'b1;
               res.empty_frame   = 1'b1;
            end
         end else begin
            phase_in = PH_PAYLOAD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HDR0;
         kind_ff  <= '0;
         mask_ff  <= 1'b0;
         left_ff  <= '0;
         rem_ff   <= '0;
         key_ff   <= '0;
         pos_ff   <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         kind_ff  <= kind_in;
         mask_ff  <= mask_in;
         left_ff  <= left_in;
         rem_ff   <= rem_in;
         key_ff   <= key_in;
         pos_ff   <= pos_in;
      end
   end

   a_close_locks: assert property (@(posedge clock) disable iff (reset)
      step && res.emit && res.close_seen |=> phase_ff == PH_CLOSED)
      else $error("close result without entering closed phase");

   a_closed_stays: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_CLOSED |=> phase_ff == PH_CLOSED)
      else $error("left closed phase without reset");

   a_empty_shape: assert property (@(posedge clock) disable iff (reset)
      res.emit && res.empty_frame |-> res.last_in_frame && res.payload_byte == 8'd0)
      else $error("empty-frame result malformed");

   a_payload_nonzero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> rem_ff != 64'd0)
      else $error("payload phase with zero bytes remaining");

endmodule

[hdl/wsd_out_reg.sv]
// ----------------------------------------------------------------------------
// wsd_out_reg
// Result register: holds one result item until the consumer takes it.
// ----------------------------------------------------------------------------
module wsd_out_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  wsd_pkg::res_type res,
   output logic             space,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [7:0]       rsp_payload_byte,
   output logic             rsp_last_in_frame,
   output logic             rsp_empty_frame,
   output logic             rsp_close_seen
);
   import wsd_pkg::*;

   logic    valid_ff, valid_in;
   res_type data_ff;
   logic    load;

   assign space = !valid_ff || rsp_ready;
   assign load  = step && res.emit;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= res;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_payload_byte  = data_ff.payload_byte;
   assign rsp_last_in_frame = data_ff.last_in_frame;
   assign rsp_empty_frame   = data_ff.empty_frame;
   assign rsp_close_seen    = data_ff.close_seen;

endmodule

[hdl/websocket_frame_deframer.sv]
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Parses a WebSocket receive byte stream and delivers unmasked text bytes and close results.
// ----------------------------------------------------------------------------
// The block takes one stream byte per cycle and sustains that rate: each
// byte is held in the input register, is parsed by the header and payload
// logic, and any result lands in the output register. Input stalls only
// while a result is held in the output register and rsp_ready is low.
// After a close result all further bytes are taken and dropped until
// reset.
module websocket_frame_deframer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_payload_byte,
   output logic       rsp_last_in_frame,
   output logic       rsp_empty_frame,
   output logic       rsp_close_seen
);
   import wsd_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       space;
   logic       step;
   res_type    res;

   assign step      = in_valid_ff && space;
   assign req_ready = !in_valid_ff || step;

   always_comb begin
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_data_byte;
      end
   end

   wsd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .data_byte (in_byte_ff),
      .res       (res)
   );

   wsd_out_reg u_out (
      .clock             (clock),
      .reset             (reset),
      .step              (step),
      .res               (res),
      .space             (space),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_last_in_frame (rsp_last_in_frame),
      .rsp_empty_frame   (rsp_empty_frame),
      .rsp_close_seen    (rsp_close_seen)
   );

endmodule
